>>> design/chip8_pkg.sv
package chip8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int FB_AW       = $clog2(SCREEN_H);
    localparam int XPOS_W      = $clog2(SCREEN_W);

    localparam logic [11:0] PC_RESET   = 12'd512;
    localparam logic [11:0] FONT_RESET = 12'd80;

    // config register indexes
    localparam logic CFG_FONT_BASE = 1'b0;

    // actions
    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // top opcode nibbles
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDX  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] OPW_CLS = 16'h00E0;
    localparam logic [15:0] OPW_RET = 16'h00EE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] F_GETDT = 8'h07;
    localparam logic [7:0] F_WAITK = 8'h0A;
    localparam logic [7:0] F_SETDT = 8'h15;
    localparam logic [7:0] F_SETST = 8'h18;
    localparam logic [7:0] F_ADDI  = 8'h1E;
    localparam logic [7:0] F_FONT  = 8'h29;
    localparam logic [7:0] F_BCD   = 8'h33;
    localparam logic [7:0] F_STORE = 8'h55;
    localparam logic [7:0] F_LOAD  = 8'h65;

    // 8xyN sub-ops
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] instr_word;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
        logic [7:0]  delay_now;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [4:0]  frame_row;
    } in_t;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [11:0] index_now;
        logic [7:0]  flag_reg;
        logic        delay_set;
        logic [7:0]  delay_value;
        logic        sound_set;
        logic [7:0]  sound_value;
        logic        key_wait;
        logic [63:0] read_data;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic       has_flag;
        logic       flag;
        logic [7:0] res;
    } alu_t;

endpackage

>>> design/chip8_alu.sv
module chip8_alu (
    input  logic [3:0]      op_n,
    input  logic [7:0]      vx,
    input  logic [7:0]      vy,
    input  logic            x_is_f,
    input  logic            y_is_f,
    output chip8_pkg::alu_t alu
);
    import chip8_pkg::*;

    logic [8:0] sum;
    logic [7:0] a;
    logic [7:0] b;

    // flag-first ops: a VF operand sees the new flag
    always_comb
    begin
        sum = {1'b0, vx} + {1'b0, vy};
        alu = '0;
        a   = vx;
        b   = vy;
        alu.valid = 1'b1;
        case (op_n)
            ALU_MOV: alu.res = vy;
            ALU_OR:  alu.res = vx | vy;
            ALU_AND: alu.res = vx & vy;
            ALU_XOR: alu.res = vx ^ vy;
            ALU_ADD:
            begin
                alu.has_flag = 1'b1;
                alu.flag     = sum[8];
                alu.res      = sum[7:0];
            end
            ALU_SUB:
            begin
                alu.has_flag = 1'b1;
                alu.flag     = vx >= vy;
                a = x_is_f ? {7'b0, alu.flag} : vx;
                b = y_is_f ? {7'b0, alu.flag} : vy;
                alu.res = a - b;
            end
            ALU_SHR:
            begin
                alu.has_flag = 1'b1;
                alu.flag     = vx[0];
                a = x_is_f ? {7'b0, alu.flag} : vx;
                alu.res = a >> 1;
            end
            ALU_RSB:
            begin
                alu.has_flag = 1'b1;
                alu.flag     = vy >= vx;
                a = x_is_f ? {7'b0, alu.flag} : vx;
                b = y_is_f ? {7'b0, alu.flag} : vy;
                alu.res = b - a;
            end
            ALU_SHL:
            begin
                alu.has_flag = 1'b1;
                alu.flag     = vx[7];
                a = x_is_f ? {7'b0, alu.flag} : vx;
                alu.res = a << 1;
            end
            default: alu.valid = 1'b0;
        endcase
    end

endmodule

>>> design/chip8_instruction_execute_top.sv
// CHIP-8 execution core. Pulse start with a command word while busy is low;
// exactly one result word follows on result, qualified by a one-cycle done
// strobe that cannot be stalled, so the receiver must capture it. After reset
// the core zeroes main memory and the data registers with busy high. An
// instruction reads its two register operands in turn; 00EE and 8xy4/5/6/7/E
// writing VF apart from Vx (x not F) take a further step, Dxyn reads and
// writes each sprite row fetched, Fx33 writes three digits, Fx55/Fx65 move
// V0..Vx in turn. Load, memory and frame-row reads skip the register reads.
// The register file and memories have one read and one write port and a
// registered read, and every register operand or memory byte is one access.
// Configuration writes (font base) are taken at any time but belong in idle.
module chip8_instruction_execute_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  chip8_pkg::in_t    item,
    output logic              done,
    output chip8_pkg::out_t   result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [11:0]       cfg_data
);
    import chip8_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ISSUE, S_RX, S_RY, S_EXEC, S_RET, S_D_RD, S_D_WR,
        S_WVF, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_RDFB, S_RDMEM, S_FIN
    } state_t;

    // storage
    logic [7:0]          mem_ram [MEM_BYTES];
    logic [7:0]          rf_ram  [16];
    logic [11:0]         stk_ram [STACK_DEPTH];
    logic [SCREEN_W-1:0] fb_ram  [SCREEN_H];

    logic [7:0]          mem_q, rf_q;
    logic [11:0]         stk_q;
    logic [SCREEN_W-1:0] fb_q;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_wa, mem_ra;
    logic [7:0]          mem_wd;
    logic                rf_we;
    logic [3:0]          rf_wa, rf_ra;
    logic [7:0]          rf_wd;
    logic                stk_we;
    logic [STK_AW-1:0]   stk_wa, stk_ra;
    logic [11:0]         stk_wd;
    logic                fb_we;
    logic [FB_AW-1:0]    fb_wa, fb_ra;
    logic [SCREEN_W-1:0] fb_wd;

    // control and architectural registers
    state_t              state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [MEM_AW-1:0]   clr_reg, clr_next;
    in_t                 it_reg, it_next;
    logic [11:0]         pc_reg, pc_next;
    logic [11:0]         index_reg, index_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [7:0]          vf_reg, vf_next;
    logic [11:0]         font_reg;
    logic [7:0]          vx_reg, vx_next;
    logic [7:0]          vy_reg, vy_next;
    logic                flag_bit_reg, flag_bit_next;
    logic [11:0]         bcd_reg, bcd_next;
    logic [SCREEN_H-1:0] fbv_reg, fbv_next;
    out_t                res_reg, res_next;
    logic                done_reg, done_next;

    // decode
    logic [15:0]         op;
    logic [3:0]          op_x, op_y, op_n;
    logic [7:0]          op_nn;
    logic [11:0]         op_nnn;
    logic [12:0]         addr13;
    logic                addr_ok;
    logic [12:0]         maddr13;
    logic                maddr_ok;
    logic [12:0]         isum13;
    logic [FB_AW:0]      py;
    logic [SCREEN_W-1:0] row_old, spr_mask;
    logic [DEPTH_W-1:0]  depth_m1;
    alu_t                alu_out;

    function automatic logic [3:0] lowest_key(input logic [15:0] keys);
        logic [3:0] k;
        k = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (keys[i])
                k = 4'(i);
        end
        return k;
    endfunction

    // double dabble, three BCD digits
    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (s[11:8] >= 4'd5)
                s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5)
                s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5)
                s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

    chip8_alu u_alu (
        .op_n   (op_n),
        .vx     (vx_reg),
        .vy     (vy_reg),
        .x_is_f (op_x == 4'hF),
        .y_is_f (op_y == 4'hF),
        .alu    (alu_out)
    );

    assign op     = it_reg.instr_word;
    assign op_x   = op[11:8];
    assign op_y   = op[7:4];
    assign op_n   = op[3:0];
    assign op_nn  = op[7:0];
    assign op_nnn = op[11:0];

    assign addr13   = {1'b0, index_reg} + 13'(cnt_reg);
    assign addr_ok  = addr13 < 13'(MEM_BYTES);
    assign maddr13  = {1'b0, it_reg.mem_address};
    assign maddr_ok = maddr13 < 13'(MEM_BYTES);
    assign isum13   = {1'b0, index_reg} + 13'(vx_reg);
    assign py       = (FB_AW+1)'(vy_reg[FB_AW-1:0]) + (FB_AW+1)'(cnt_reg);
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign row_old  = fbv_reg[py[FB_AW-1:0]] ? fb_q : '0;
    assign spr_mask = (SCREEN_W'(mem_q) << (SCREEN_W - 8)) >> vx_reg[XPOS_W-1:0];

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        it_next       = it_reg;
        pc_next       = pc_reg;
        index_next    = index_reg;
        depth_next    = depth_reg;
        vf_next       = vf_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        flag_bit_next = flag_bit_reg;
        bcd_next      = bcd_reg;
        fbv_next      = fbv_reg;
        res_next      = res_reg;
        done_next     = 1'b0;

        mem_we = 1'b0;
        mem_wa = addr13[MEM_AW-1:0];
        mem_wd = 8'd0;
        mem_ra = addr13[MEM_AW-1:0];
        rf_we  = 1'b0;
        rf_wa  = op_x;
        rf_wd  = 8'd0;
        rf_ra  = op_x;
        stk_we = 1'b0;
        stk_wa = depth_reg[STK_AW-1:0];
        stk_wd = pc_reg;
        stk_ra = depth_m1[STK_AW-1:0];
        fb_we  = 1'b0;
        fb_wa  = py[FB_AW-1:0];
        fb_wd  = row_old ^ spr_mask;
        fb_ra  = py[FB_AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                if (clr_reg < MEM_AW'(16))
                begin
                    rf_we = 1'b1;
                    rf_wa = clr_reg[3:0];
                end
                clr_next = clr_reg + MEM_AW'(1);
                if (clr_reg == MEM_AW'(MEM_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    it_next    = item;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                res_next = '0;
                case (it_reg.action)
                    ACT_LOAD:
                    begin
                        mem_we     = maddr_ok;
                        mem_wa     = maddr13[MEM_AW-1:0];
                        mem_wd     = it_reg.mem_data;
                        state_next = S_FIN;
                    end
                    ACT_FRAME:
                    begin
                        fb_ra      = it_reg.frame_row[FB_AW-1:0];
                        state_next = S_RDFB;
                    end
                    ACT_READ:
                    begin
                        mem_ra     = maddr13[MEM_AW-1:0];
                        state_next = S_RDMEM;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 12'd2;
                        rf_ra      = (op[15:12] == OP_JPV0) ? 4'd0 : op_x;
                        state_next = S_RX;
                    end
                endcase
            end
            S_RDFB:
            begin
                res_next.read_data = fbv_reg[it_reg.frame_row[FB_AW-1:0]] ? fb_q : '0;
                state_next = S_FIN;
            end
            S_RDMEM:
            begin
                res_next.read_data = maddr_ok ? 64'(mem_q) : 64'd0;
                state_next = S_FIN;
            end
            S_RX:
            begin
                vx_next    = rf_q;
                rf_ra      = op_y;
                state_next = S_RY;
            end
            S_RY:
            begin
                vy_next    = rf_q;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                cnt_next   = 4'd0;
                case (op[15:12])
                    OP_SYS:
                    begin
                        if (op == OPW_CLS)
                            fbv_next = '0;
                        else if (op == OPW_RET && depth_reg != '0)
                            state_next = S_RET;
                    end
                    OP_JP: pc_next = op_nnn;
                    OP_CALL:
                    begin
                        if (depth_reg < DEPTH_W'(STACK_DEPTH))
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            pc_next    = op_nnn;
                        end
                    end
                    OP_SEI:
                        if (vx_reg == op_nn)
                            pc_next = pc_reg + 12'd2;
                    OP_SNEI:
                        if (vx_reg != op_nn)
                            pc_next = pc_reg + 12'd2;
                    OP_SER:
                        if (op_n == 4'd0 && vx_reg == vy_reg)
                            pc_next = pc_reg + 12'd2;
                    OP_SNER:
                        if (op_n == 4'd0 && vx_reg != vy_reg)
                            pc_next = pc_reg + 12'd2;
                    OP_LDI:
                    begin
                        rf_we = 1'b1;
                        rf_wd = op_nn;
                    end
                    OP_ADDI:
                    begin
                        rf_we = 1'b1;
                        rf_wd = vx_reg + op_nn;
                    end
                    OP_ALU:
                    begin
                        if (alu_out.valid)
                        begin
                            rf_we = 1'b1;
                            rf_wd = alu_out.res;
                            // flag goes to VF separately unless VF is the target
                            if (alu_out.has_flag && op_x != 4'hF)
                            begin
                                flag_bit_next = alu_out.flag;
                                state_next    = S_WVF;
                            end
                        end
                    end
                    OP_LDX: index_next = op_nnn;
                    OP_JPV0: pc_next = op_nnn + 12'(vx_reg);
                    OP_RND:
                    begin
                        rf_we = 1'b1;
                        rf_wd = it_reg.random_byte & op_nn;
                    end
                    OP_DRW:
                    begin
                        flag_bit_next = 1'b0;
                        state_next    = (op_n == 4'd0) ? S_WVF : S_D_RD;
                    end
                    OP_KEY:
                    begin
                        if (op_nn == KEY_SKP && vx_reg[7:4] == 4'd0
                            && it_reg.keys_down[vx_reg[3:0]])
                            pc_next = pc_reg + 12'd2;
                        else if (op_nn == KEY_SKNP && vx_reg[7:4] == 4'd0
                            && !it_reg.keys_down[vx_reg[3:0]])
                            pc_next = pc_reg + 12'd2;
                    end
                    default:
                    begin
                        case (op_nn)
                            F_GETDT:
                            begin
                                rf_we = 1'b1;
                                rf_wd = it_reg.delay_now;
                            end
                            F_WAITK:
                            begin
                                if (it_reg.keys_down != 16'd0)
                                begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'd0, lowest_key(it_reg.keys_down)};
                                end
                                else
                                begin
                                    pc_next           = pc_reg - 12'd2;
                                    res_next.key_wait = 1'b1;
                                end
                            end
                            F_SETDT:
                            begin
                                res_next.delay_set   = 1'b1;
                                res_next.delay_value = vx_reg;
                            end
                            F_SETST:
                            begin
                                res_next.sound_set   = 1'b1;
                                res_next.sound_value = vx_reg;
                            end
                            F_ADDI:
                                if (isum13 < 13'(MEM_BYTES))
                                    index_next = isum13[11:0];
                            F_FONT:
                                if (vx_reg[7:4] == 4'd0)
                                    index_next = font_reg + {6'd0, vx_reg[3:0], 2'd0}
                                               + {8'd0, vx_reg[3:0]};
                            F_BCD:
                            begin
                                bcd_next   = to_bcd(vx_reg);
                                state_next = S_BCD;
                            end
                            F_STORE: state_next = S_ST_RD;
                            F_LOAD:  state_next = S_LD_RD;
                            default: ;
                        endcase
                    end
                endcase
            end
            S_RET:
            begin
                pc_next    = stk_q;
                depth_next = depth_m1;
                state_next = S_FIN;
            end
            S_D_RD:
            begin
                state_next = addr_ok ? S_D_WR : S_WVF;
            end
            S_D_WR:
            begin
                if (py < (FB_AW+1)'(SCREEN_H))
                begin
                    fb_we = 1'b1;
                    fbv_next[py[FB_AW-1:0]] = 1'b1;
                    if ((row_old & spr_mask) != '0)
                        flag_bit_next = 1'b1;
                end
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == op_n - 4'd1) ? S_WVF : S_D_RD;
            end
            S_WVF:
            begin
                rf_we      = 1'b1;
                rf_wa      = 4'hF;
                rf_wd      = {7'd0, flag_bit_reg};
                state_next = S_FIN;
            end
            S_BCD:
            begin
                mem_we = addr_ok;
                case (cnt_reg[1:0])
                    2'd0:    mem_wd = {4'd0, bcd_reg[11:8]};
                    2'd1:    mem_wd = {4'd0, bcd_reg[7:4]};
                    default: mem_wd = {4'd0, bcd_reg[3:0]};
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2)
                    state_next = S_FIN;
            end
            S_ST_RD:
            begin
                rf_ra      = cnt_reg;
                state_next = S_ST_WR;
            end
            S_ST_WR:
            begin
                mem_we   = addr_ok;
                mem_wd   = rf_q;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == op_x) ? S_FIN : S_ST_RD;
            end
            S_LD_RD:
            begin
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                rf_we    = addr_ok;
                rf_wa    = cnt_reg;
                rf_wd    = mem_q;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == op_x) ? S_FIN : S_LD_RD;
            end
            S_FIN:
            begin
                res_next.pc_now    = pc_reg;
                res_next.index_now = index_reg;
                res_next.flag_reg  = vf_reg;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // VF mirror for the result word
        if (rf_we && rf_wa == 4'hF)
            vf_next = rf_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            pc_reg       <= PC_RESET;
            index_reg    <= '0;
            depth_reg    <= '0;
            vf_reg       <= '0;
            font_reg     <= FONT_RESET;
            fbv_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            index_reg <= index_next;
            depth_reg <= depth_next;
            vf_reg    <= vf_next;
            fbv_reg   <= fbv_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == CFG_FONT_BASE)
                font_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg       <= it_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        flag_bit_reg <= flag_bit_next;
        bcd_reg      <= bcd_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_ram[mem_wa] <= mem_wd;
        mem_q <= mem_ram[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_ram[rf_wa] <= rf_wd;
        rf_q <= rf_ram[rf_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_ram[stk_wa] <= stk_wd;
        stk_q <= stk_ram[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
            fb_ram[fb_wa] <= fb_wd;
        fb_q <= fb_ram[fb_ra];
    end

`ifndef NO_ASSERTIONS
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("done without finish");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth overflow");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");
    a_wait_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.key_wait |-> !result.delay_set && !result.sound_set)
        else $error("key wait with timer write");
`endif

endmodule

>>> tb/tb_chip8_instruction_execute_top.sv
`timescale 1ns / 100ps

module tb_chip8_instruction_execute_top;
    import chip8_pkg::*;

    // A model of the core's state (registers, index, PC, call stack, memory and
    // frame buffer) runs alongside the DUT; every word accepted on start is run
    // through it and the expected result word is queued. Each done strobe pops
    // the oldest expected word and compares it field by field.

    localparam logic CFG_PROG_START = 1'b1;   // second config index, not decoded by the core
    localparam int   HALF_PERIOD    = 6;
    localparam int   IDLE_LIMIT     = 20000;  // covers the clear pass after reset
    localparam int   SETTLE_CYCLES  = 64;     // longest op is well under this

    // Expected-result store with the compare logic.
    class result_board;
        out_t pending[$];
        int   errors = 0;

        function void note(out_t exp_word);
            pending.push_back(exp_word);
        endfunction

        function void field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
            end
        endfunction

        function void check(out_t got);
            out_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $realtime, got);
                return;
            end
            e = pending.pop_front();
            field("pc_now", e.pc_now, got.pc_now);
            field("index_now", e.index_now, got.index_now);
            field("flag_reg", e.flag_reg, got.flag_reg);
            field("delay_set", e.delay_set, got.delay_set);
            field("delay_value", e.delay_value, got.delay_value);
            field("sound_set", e.sound_set, got.sound_set);
            field("sound_value", e.sound_value, got.sound_value);
            field("key_wait", e.key_wait, got.key_wait);
            field("read_data", e.read_data, got.read_data);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         item = '0;
    logic        done;
    out_t        result;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_data = '0;

    result_board board = new();
    int          gap_pct = 0;
    int          idle_cnt = 0;

    // Model state of the core.
    logic [7:0]  vreg [16];
    logic [11:0] idx_q;
    logic [11:0] pc_q;
    logic [11:0] call_stk [STACK_DEPTH];
    int          stk_ptr;
    logic [7:0]  ram [MEM_BYTES];
    logic [63:0] screen [SCREEN_H];
    logic [11:0] font_q = FONT_RESET;
    logic [11:0] pstart_q = PC_RESET;

    chip8_instruction_execute_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void ram_put(int addr, logic [7:0] v);
        if (addr < MEM_BYTES)
            ram[addr] = v;
    endfunction

    // Sprite draw: start point wraps, right/bottom clip, VF = collision.
    function automatic void draw(int xr, int yr, int rows);
        int x0, y0, py, px;
        logic [7:0]  bits;
        logic [63:0] m;
        x0 = vreg[xr] % SCREEN_W;
        y0 = vreg[yr] % SCREEN_H;
        vreg[15] = 8'd0;
        for (int r = 0; r < rows; r++)
        begin
            py = y0 + r;
            if (idx_q + r >= MEM_BYTES)
                break;
            bits = ram[idx_q + r];
            if (py >= SCREEN_H)
                continue;
            for (int c = 0; c < 8; c++)
            begin
                px = x0 + c;
                if (px >= SCREEN_W || !bits[7-c])
                    continue;
                m = 64'd1 << (SCREEN_W - 1 - px);
                if (screen[py] & m)
                    vreg[15] = 8'd1;
                screen[py] ^= m;
            end
        end
    endfunction

    // Applies one command word to the model and returns the expected result.
    function automatic out_t exec_word(in_t w);
        out_t        o;
        logic [3:0]  x, y, n;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic        skip;
        int          k;
        o = '0;
        x = w.instr_word[11:8];
        y = w.instr_word[7:4];
        n = w.instr_word[3:0];
        nn = w.instr_word[7:0];
        nnn = w.instr_word[11:0];
        skip = 1'b0;
        case (w.action)
            ACT_LOAD:  ram_put(w.mem_address, w.mem_data);
            ACT_FRAME: o.read_data = screen[w.frame_row];
            ACT_READ:  o.read_data = {56'd0, ram[w.mem_address]};
            default:
            begin
                pc_q = pc_q + 12'd2;
                case (w.instr_word[15:12])
                    OP_SYS:
                    begin
                        if (w.instr_word == OPW_CLS)
                        begin
                            for (int r = 0; r < SCREEN_H; r++)
                                screen[r] = '0;
                        end
                        else if (w.instr_word == OPW_RET && stk_ptr > 0)
                        begin
                            stk_ptr--;
                            pc_q = call_stk[stk_ptr];
                        end
                    end
                    OP_JP:   pc_q = nnn;
                    OP_CALL:
                    begin
                        if (stk_ptr < STACK_DEPTH)
                        begin
                            call_stk[stk_ptr] = pc_q;
                            stk_ptr++;
                            pc_q = nnn;
                        end
                    end
                    OP_SEI:  skip = (vreg[x] == nn);
                    OP_SNEI: skip = (vreg[x] != nn);
                    OP_SER:  skip = (n == 0) && (vreg[x] == vreg[y]);
                    OP_LDI:  vreg[x] = nn;
                    OP_ADDI: vreg[x] = vreg[x] + nn;
                    OP_ALU:
                    begin
                        case (n)
                            ALU_MOV: vreg[x] = vreg[y];
                            ALU_OR:  vreg[x] = vreg[x] | vreg[y];
                            ALU_AND: vreg[x] = vreg[x] & vreg[y];
                            ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                            ALU_ADD:
                            begin
                                sum = vreg[x] + vreg[y];
                                vreg[15] = {7'd0, sum[8]};
                                vreg[x] = sum[7:0];
                            end
                            // flag first, then operands are read again
                            ALU_SUB:
                            begin
                                vreg[15] = {7'd0, vreg[x] >= vreg[y]};
                                vreg[x] = vreg[x] - vreg[y];
                            end
                            ALU_SHR:
                            begin
                                vreg[15] = {7'd0, vreg[x][0]};
                                vreg[x] = vreg[x] >> 1;
                            end
                            ALU_RSB:
                            begin
                                vreg[15] = {7'd0, vreg[y] >= vreg[x]};
                                vreg[x] = vreg[y] - vreg[x];
                            end
                            ALU_SHL:
                            begin
                                vreg[15] = {7'd0, vreg[x][7]};
                                vreg[x] = vreg[x] << 1;
                            end
                            default: ;
                        endcase
                    end
                    OP_SNER: skip = (n == 0) && (vreg[x] != vreg[y]);
                    OP_LDX:  idx_q = nnn;
                    OP_JPV0: pc_q = nnn + vreg[0];
                    OP_RND:  vreg[x] = w.random_byte & nn;
                    OP_DRW:  draw(x, y, n);
                    OP_KEY:
                    begin
                        if (nn == KEY_SKP)
                            skip = vreg[x] < 16 && w.keys_down[vreg[x][3:0]];
                        else if (nn == KEY_SKNP)
                            skip = vreg[x] < 16 && !w.keys_down[vreg[x][3:0]];
                    end
                    default:
                    begin
                        case (nn)
                            F_GETDT: vreg[x] = w.delay_now;
                            F_WAITK:
                            begin
                                for (k = 0; k < 16; k++)
                                    if (w.keys_down[k])
                                        break;
                                if (k < 16)
                                begin
                                    vreg[x] = k[7:0];
                                end
                                else
                                begin
                                    pc_q = pc_q - 12'd2;
                                    o.key_wait = 1'b1;
                                end
                            end
                            F_SETDT:
                            begin
                                o.delay_set = 1'b1;
                                o.delay_value = vreg[x];
                            end
                            F_SETST:
                            begin
                                o.sound_set = 1'b1;
                                o.sound_value = vreg[x];
                            end
                            F_ADDI:
                                if (idx_q + vreg[x] < MEM_BYTES)
                                    idx_q = idx_q + vreg[x];
                            F_FONT:
                                if (vreg[x] < 16)
                                    idx_q = font_q + 12'd5 * vreg[x];
                            F_BCD:
                            begin
                                ram_put(idx_q, vreg[x] / 100);
                                ram_put(idx_q + 1, (vreg[x] / 10) % 10);
                                ram_put(idx_q + 2, vreg[x] % 10);
                            end
                            F_STORE:
                                for (int i = 0; i <= x; i++)
                                    ram_put(idx_q + i, vreg[i]);
                            F_LOAD:
                                for (int i = 0; i <= x; i++)
                                    if (idx_q + i < MEM_BYTES)
                                        vreg[i] = ram[idx_q + i];
                            default: ;
                        endcase
                    end
                endcase
                if (skip)
                    pc_q = pc_q + 12'd2;
            end
        endcase
        o.pc_now = pc_q;
        o.index_now = idx_q;
        o.flag_reg = vreg[15];
        return o;
    endfunction

    // Monitors: inputs change on negedge, so sampling on posedge is race free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note(exec_word(item));
            if (done)
                board.check(result);
            if ((start && !busy) || done)
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Word with random side fields; keys are empty now and then for Fx0A.
    function automatic in_t mk(logic [1:0] act, logic [15:0] op);
        in_t w;
        w.action      = act;
        w.instr_word  = op;
        w.random_byte = 8'($urandom);
        w.keys_down   = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
        w.delay_now   = 8'($urandom);
        w.mem_address = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(63));
        w.mem_data    = 8'($urandom);
        w.frame_row   = 5'($urandom);
        return w;
    endfunction

    // Opcode picker: valid encodings mostly, raw noise the rest.
    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        logic [3:0]  alu_sel [9];
        logic [7:0]  f_sel [9];
        alu_sel = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                    ALU_RSB, ALU_SHR, ALU_SHL};
        f_sel = '{F_GETDT, F_WAITK, F_SETDT, F_SETST, F_ADDI, F_FONT,
                  F_BCD, F_STORE, F_LOAD};
        op = 16'($urandom);
        if ($urandom_range(9) == 0)
            return op;
        case (op[15:12])
            OP_SYS:  op = $urandom_range(1) ? OPW_CLS : OPW_RET;
            OP_SER, OP_SNER: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
            OP_LDI:  if ($urandom_range(1)) op[7:0] = 8'($urandom_range(17));
            OP_ALU:  op[3:0] = alu_sel[$urandom_range(8)];
            OP_LDX:  if ($urandom_range(2) != 0)
                         op[11:0] = $urandom_range(1) ? 12'($urandom_range(63))
                                                      : 12'($urandom_range(4080, 4095));
            OP_KEY:  op[7:0] = $urandom_range(1) ? KEY_SKP : KEY_SKNP;
            OP_MISC: op[7:0] = f_sel[$urandom_range(8)];
            default: ;
        endcase
        return op;
    endfunction

    // Drive one word from a falling edge; start stays high across back-to-back
    // words. busy only moves at a rising edge, so its value at a falling edge
    // holds at the next rising edge, which then takes the word.
    task automatic send(input in_t w);
        item  <= w;
        start <= 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // Config writes only once the core is quiet.
    task automatic write_cfg(input logic sel, input logic [11:0] val);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_FONT_BASE)
            font_q = val;
        else
            pstart_q = val;   // the core does not decode this index
    endtask

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 2)
            begin
                // overflow the call stack by one call
                for (int c = 0; c <= STACK_DEPTH; c++)
                    send(mk(ACT_EXEC, {OP_CALL, 12'($urandom)}));
            end
            else if (r < 4)
            begin
                for (int c = 0; c <= STACK_DEPTH; c++)
                    send(mk(ACT_EXEC, OPW_RET));
            end
            else if (r < 70)
            begin
                send(mk(ACT_EXEC, rand_op()));
            end
            else if (r < 84)
            begin
                send(mk(ACT_LOAD, 16'($urandom)));
            end
            else if (r < 92)
            begin
                send(mk(ACT_FRAME, 16'($urandom)));
            end
            else
            begin
                send(mk(ACT_READ, 16'($urandom)));
            end
        end
    endtask

    initial
    begin
        in_t w;
        for (int i = 0; i < 16; i++)
            vreg[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++)
            ram[i] = '0;
        for (int i = 0; i < SCREEN_H; i++)
            screen[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
            call_stk[i] = '0;
        idx_q   = '0;
        pc_q    = PC_RESET;
        stk_ptr = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corner cases
        send(mk(ACT_LOAD, 16'h0000));
        w = mk(ACT_LOAD, 16'h0000); w.mem_address = 12'hFFF; w.mem_data = 8'hFF;
        send(w);
        w = mk(ACT_READ, 16'h0000); w.mem_address = 12'hFFF; send(w);
        send(mk(ACT_EXEC, 16'h60FF));               // V0 = 0xFF
        send(mk(ACT_EXEC, 16'h61FF));
        send(mk(ACT_EXEC, 16'h8014));               // add with carry
        send(mk(ACT_EXEC, 16'h8F05));               // VF as destination
        send(mk(ACT_EXEC, 16'h8F17));
        send(mk(ACT_EXEC, 16'h801E));
        send(mk(ACT_EXEC, 16'h8016));
        send(mk(ACT_EXEC, 16'h5011));               // unknown: 5xyN with N set
        send(mk(ACT_EXEC, 16'h00EE));               // return on empty stack
        send(mk(ACT_EXEC, 16'h2FFE));
        send(mk(ACT_EXEC, 16'h00EE));
        send(mk(ACT_EXEC, 16'hBFFF));               // jump wraps past 4095
        w = mk(ACT_EXEC, 16'hF00A); w.keys_down = 16'd0; send(w);
        w = mk(ACT_EXEC, 16'hF00A); w.keys_down = 16'h8000; send(w);
        send(mk(ACT_EXEC, 16'h63FF));
        send(mk(ACT_EXEC, 16'hF329));               // glyph for Vx > 15: no change
        send(mk(ACT_EXEC, 16'hAFFE));
        send(mk(ACT_EXEC, 16'hF333));               // BCD past end of memory
        send(mk(ACT_EXEC, 16'hF31E));
        send(mk(ACT_EXEC, 16'hD13F));               // sprite wraps and clips
        w = mk(ACT_FRAME, 16'h0000); w.frame_row = 5'd31; send(w);
        send(mk(ACT_EXEC, 16'hF315));
        send(mk(ACT_EXEC, 16'hF318));

        gap_pct = 29;
        random_phase(180);
        write_cfg(CFG_FONT_BASE, 12'hFFF);
        write_cfg(CFG_PROG_START, 12'h000);

        gap_pct = 45;
        random_phase(90);
        drain();   // let the core run dry once mid-phase
        random_phase(90);
        write_cfg(CFG_FONT_BASE, 12'h000);
        write_cfg(CFG_PROG_START, 12'hFFF);

        gap_pct = 0;
        random_phase(90);
        write_cfg(CFG_FONT_BASE, 12'($urandom));
        random_phase(90);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (board.pending.size() != 0)
            board.errors++;
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
design/chip8_pkg.sv
design/chip8_alu.sv
design/chip8_instruction_execute_top.sv
tb/tb_chip8_instruction_execute_top.sv
